// File: src/quaternion_slerp_assert.svh
// assertion helpers, empty when synthesizing
`ifndef QUATERNION_SLERP_ASSERT_SVH
`define QUATERNION_SLERP_ASSERT_SVH

`ifndef SYNTHESIS
`define QS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define QS_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> prop) \
    else $error("assertion failed");
`else
`define QS_ASSERT(label, clk, rst_n, prop)
`define QS_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

// File: src/qs_pkg.sv
package qs_pkg;

  // cordic datapath width, angles in q30 radians, vectors in q28
  localparam int CW = 34;
  localparam logic signed [CW-1:0] INV_GAIN = 34'sd163008219;

  // square root: radicand bits, root bits, remainder bits
  localparam int SQ_RAD = 62;
  localparam int SQ_Q = 31;
  localparam int SQ_R = 34;

  // long division: divisor width and quotient bits
  localparam int DW = 31;
  localparam int DQ = 29;

  localparam logic [14:0] NEAR_RESET = 15'd15565;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic [SQ_RAD-1:0] rad;
    logic [SQ_R-1:0]   rem;
    logic [SQ_Q-1:0]   root;
  } sqrt_t;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [DW-1:0] dvs;
    logic [DQ-1:0] num;
    logic [DQ-1:0] quo;
  } div_t;

  // round(atan(2^-i) * 2^30)
  function automatic logic signed [CW-1:0] atan_q30(input int i);
    case (i)
      0:  return 34'sd843314857;
      1:  return 34'sd497837829;
      2:  return 34'sd263043837;
      3:  return 34'sd133525159;
      4:  return 34'sd67021687;
      5:  return 34'sd33543516;
      6:  return 34'sd16775851;
      7:  return 34'sd8388437;
      8:  return 34'sd4194283;
      9:  return 34'sd2097149;
      10: return 34'sd1048576;
      11: return 34'sd524288;
      12: return 34'sd262144;
      13: return 34'sd131072;
      14: return 34'sd65536;
      15: return 34'sd32768;
      16: return 34'sd16384;
      17: return 34'sd8192;
      18: return 34'sd4096;
      19: return 34'sd2048;
      20: return 34'sd1024;
      21: return 34'sd512;
      22: return 34'sd256;
      23: return 34'sd128;
      default: return '0;
    endcase
  endfunction

endpackage

// File: src/qs_sqrt_cell.sv
// one radicand digit pair per cell
module qs_sqrt_cell import qs_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  sqrt_t d_i,
  output sqrt_t q_o
);

  logic [SQ_R-1:0] remx;
  logic [SQ_R-1:0] trial;
  logic            ge;
  sqrt_t           nxt_d;
  sqrt_t           nxt_q;

  always_comb begin
    remx  = {d_i.rem[SQ_R-3:0], d_i.rad[SQ_RAD-1 -: 2]};
    trial = {{(SQ_R-SQ_Q-2){1'b0}}, d_i.root, 2'b01};
    ge    = remx >= trial;
    nxt_d.rad  = {d_i.rad[SQ_RAD-3:0], 2'b00};
    nxt_d.rem  = ge ? remx - trial : remx;
    nxt_d.root = {d_i.root[SQ_Q-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nxt_q <= nxt_d;
    end
  end

  assign q_o = nxt_q;

endmodule

// File: src/qs_div_cell.sv
// one quotient bit per cell, restoring
module qs_div_cell import qs_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  div_t d_i,
  output div_t q_o
);

  logic [DW:0] remx;
  logic [DW:0] dvx;
  logic        ge;
  logic [DW:0] diff;
  div_t        nxt_d;
  div_t        nxt_q;

  always_comb begin
    remx = {d_i.rem, d_i.num[DQ-1]};
    dvx  = {1'b0, d_i.dvs};
    ge   = remx >= dvx;
    diff = remx - dvx;
    nxt_d.rem = ge ? diff[DW-1:0] : remx[DW-1:0];
    nxt_d.dvs = d_i.dvs;
    nxt_d.num = {d_i.num[DQ-2:0], 1'b0};
    nxt_d.quo = {d_i.quo[DQ-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nxt_q <= nxt_d;
    end
  end

  assign q_o = nxt_q;

endmodule

// File: src/qs_cordic_cell.sv
// one cordic micro-rotation, vectoring or rotating
module qs_cordic_cell import qs_pkg::*; #(
  parameter int STEP   = 0,
  parameter bit VECTOR = 1'b0
) (
  input  logic    clk_i,
  input  logic    en_i,
  input  cordic_t d_i,
  output cordic_t q_o
);

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [CW-1:0] atn;
  logic                 up;
  cordic_t              nxt_d;
  cordic_t              nxt_q;

  always_comb begin
    dx  = $signed(d_i.y) >>> STEP;
    dy  = $signed(d_i.x) >>> STEP;
    atn = atan_q30(STEP);
    // vectoring drives y to zero, rotating drives z to zero
    up  = VECTOR ? !d_i.y[CW-1] : d_i.z[CW-1];
    if (up) begin
      nxt_d.x = d_i.x + dx;
      nxt_d.y = d_i.y - dy;
      nxt_d.z = d_i.z + atn;
    end else begin
      nxt_d.x = d_i.x - dx;
      nxt_d.y = d_i.y + dy;
      nxt_d.z = d_i.z - atn;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nxt_q <= nxt_d;
    end
  end

  assign q_o = nxt_q;

endmodule

// File: src/quaternion_slerp.sv
// quaternion blend, spherical below the cosine threshold, normalized linear above
// throughput: one request per cycle unless a result stalls, set by the fully pipelined sqrt, cordic and divider rows
// a stalled result freezes the whole pipe, an input skid register takes one more request
// reset: asynchronous active low, clears valid bits and skid, threshold back to 0.95
module quaternion_slerp import qs_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [14:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] start_x_i,
  input  logic [15:0] start_y_i,
  input  logic [15:0] start_z_i,
  input  logic [15:0] start_w_i,
  input  logic [15:0] end_x_i,
  input  logic [15:0] end_y_i,
  input  logic [15:0] end_z_i,
  input  logic [15:0] end_w_i,
  input  logic [15:0] blend_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] out_x_o,
  output logic [15:0] out_y_o,
  output logic [15:0] out_z_o,
  output logic [15:0] out_w_o,
  output logic        used_linear_o,
  output logic        zero_length_o
);

  `include "quaternion_slerp_assert.svh"

  localparam int NS  = CORDIC_STEPS;
  localparam int NG  = 6;                      // front stages: clamp .. radicands
  localparam int NST = NG + SQ_Q + NS + 1 + NS + DQ + 2;

  // raw request
  typedef struct packed {
    logic [3:0][15:0] s;
    logic [3:0][15:0] e;
    logic [15:0]      b;
  } in_t;

  // side data riding along the pipe
  typedef struct packed {
    logic [3:0][15:0] s;
    logic [3:0][16:0] e;
    logic [14:0]      t;
    logic [14:0]      u;
    logic             lin;
    logic             cone;
    logic [3:0]       lneg;
    logic [3:0][29:0] m;
    logic [28:0]      c;
    logic [30:0]      len;
    logic [30:0]      ang;
    logic             wsel;
  } sd_t;

  // ---------------------------------------------------------------- control
  logic [14:0]    thr_q;
  logic           en;
  logic [NST-1:0] vld_q;
  logic           skid_v_q;
  in_t            skid_q;
  in_t            in_bus;
  in_t            src;
  logic           src_v;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !skid_v_q;
  // the whole pipe moves unless a finished result is waiting
  assign en          = !vld_q[NST-1] || out_ready_i;
  assign out_valid_o = vld_q[NST-1];

  assign in_bus.s = {start_w_i, start_z_i, start_y_i, start_x_i};
  assign in_bus.e = {end_w_i, end_z_i, end_y_i, end_x_i};
  assign in_bus.b = blend_i;
  assign src      = skid_v_q ? skid_q : in_bus;
  assign src_v    = skid_v_q || in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= NEAR_RESET;
      vld_q    <= '0;
      skid_v_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        thr_q <= cfg_data_i;
      end
      if (en) begin
        vld_q <= {vld_q[NST-2:0], src_v};
      end
      // skid catches a request that arrives while the pipe is frozen
      skid_v_q <= !en && (skid_v_q || in_valid_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en && !skid_v_q && in_valid_i) begin
      skid_q <= in_bus;
    end
  end

  // ---------------------------------------------------------- front stages
  sd_t                g_sd_q [NG];
  logic signed [31:0] p1_q   [4];
  logic signed [31:0] su_q   [2][4];
  logic signed [31:0] et_q   [2][4];
  logic signed [33:0] dot2_q;
  logic signed [31:0] l3_q   [4];
  logic        [59:0] lsq4_q [4];
  logic        [57:0] csq4_q;
  logic        [61:0] lsum5_q;
  logic        [56:0] srad5_q;

  sd_t                g0_d;
  sd_t                g3_d;
  sd_t                g4_d;
  logic        [32:0] adot;
  logic               neg;

  always_comb begin
    g0_d = '0;
    for (int k = 0; k < 4; k++) begin
      g0_d.s[k] = src.s[k];
      g0_d.e[k] = {src.e[k][15], src.e[k]};
    end
    // blend clamped to 0..1
    if (src.b[15]) begin
      g0_d.t = 15'd0;
    end else if ($signed(src.b) > 16'sd16384) begin
      g0_d.t = 15'd16384;
    end else begin
      g0_d.t = src.b[14:0];
    end
    g0_d.u = 15'd16384 - g0_d.t;
    neg    = dot2_q[33];
    adot   = neg ? 33'(34'sd0 - dot2_q) : dot2_q[32:0];
    // shortest arc and path choice
    g3_d      = g_sd_q[2];
    g3_d.lin  = adot >= {4'b0, thr_q, 14'b0};
    g3_d.cone = |adot[32:28];
    g3_d.c    = (|adot[32:28]) ? 29'h1000_0000 : {1'b0, adot[27:0]};
    for (int k = 0; k < 4; k++) begin
      g3_d.e[k] = neg ? 17'(17'sd0 - $signed(g_sd_q[2].e[k])) : g_sd_q[2].e[k];
    end
    // signs and magnitudes of the linear blend
    g4_d = g_sd_q[3];
    for (int k = 0; k < 4; k++) begin
      g4_d.lneg[k] = l3_q[k][31];
      g4_d.m[k]    = l3_q[k][31] ? 30'(-l3_q[k]) : l3_q[k][29:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_sd_q[0] <= g0_d;
      // products
      g_sd_q[1] <= g_sd_q[0];
      for (int k = 0; k < 4; k++) begin
        p1_q[k]     <= $signed(g_sd_q[0].s[k]) * $signed(g_sd_q[0].e[k][15:0]);
        su_q[0][k]  <= $signed(g_sd_q[0].s[k]) * $signed({1'b0, g_sd_q[0].u});
        et_q[0][k]  <= $signed(g_sd_q[0].e[k][15:0]) * $signed({1'b0, g_sd_q[0].t});
      end
      // dot product
      g_sd_q[2] <= g_sd_q[1];
      dot2_q    <= 34'(p1_q[0]) + 34'(p1_q[1]) + 34'(p1_q[2]) + 34'(p1_q[3]);
      su_q[1]   <= su_q[0];
      et_q[1]   <= et_q[0];
      // shortest arc, path choice, unnormalized linear blend
      g_sd_q[3] <= g3_d;
      for (int k = 0; k < 4; k++) begin
        l3_q[k] <= su_q[1][k] + (neg ? -et_q[1][k] : et_q[1][k]);
      end
      // squares
      g_sd_q[4] <= g4_d;
      for (int k = 0; k < 4; k++) begin
        lsq4_q[k] <= 60'(l3_q[k]) * 60'(l3_q[k]);
      end
      csq4_q <= g_sd_q[3].c * g_sd_q[3].c;
      // radicands
      g_sd_q[5] <= g_sd_q[4];
      lsum5_q   <= 62'(lsq4_q[0]) + 62'(lsq4_q[1]) + 62'(lsq4_q[2]) + 62'(lsq4_q[3]);
      srad5_q   <= 57'h100_0000_0000_0000 - csq4_q[56:0];
    end
  end

  // -------------------------------------------------------- square roots
  // lane 0: length of the linear blend, lane 1: sine from the cosine
  sqrt_t sq_in  [2][SQ_Q];
  sqrt_t sq_out [2][SQ_Q];
  sd_t   sq_sd_q [SQ_Q];

  assign sq_in[0][0] = '{rad: lsum5_q, rem: '0, root: '0};
  assign sq_in[1][0] = '{rad: {{(SQ_RAD-57){1'b0}}, srad5_q}, rem: '0, root: '0};

  for (genvar ln = 0; ln < 2; ln++) begin : g_sq_lane
    for (genvar k = 0; k < SQ_Q; k++) begin : g_sq_cell
      if (k > 0) begin : g_link
        assign sq_in[ln][k] = sq_out[ln][k-1];
      end
      qs_sqrt_cell u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .d_i   (sq_in[ln][k]),
        .q_o   (sq_out[ln][k])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_sd_q[0] <= g_sd_q[NG-1];
      for (int k = 1; k < SQ_Q; k++) begin
        sq_sd_q[k] <= sq_sd_q[k-1];
      end
    end
  end

  // ---------------------------------------------------- angle from cosine
  cordic_t vc_in  [NS];
  cordic_t vc_out [NS];
  sd_t     vc_sd_q [NS];
  sd_t     vc_sd0;

  always_comb begin
    vc_sd0     = sq_sd_q[SQ_Q-1];
    vc_sd0.len = sq_out[0][SQ_Q-1].root;
  end

  assign vc_in[0] = '{x: CW'(sq_sd_q[SQ_Q-1].c), y: CW'(sq_out[1][SQ_Q-1].root), z: '0};

  for (genvar k = 0; k < NS; k++) begin : g_vc
    if (k > 0) begin : g_link
      assign vc_in[k] = vc_out[k-1];
    end
    qs_cordic_cell #(.STEP(k), .VECTOR(1'b1)) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   (vc_in[k]),
      .q_o   (vc_out[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vc_sd_q[0] <= vc_sd0;
      for (int k = 1; k < NS; k++) begin
        vc_sd_q[k] <= vc_sd_q[k-1];
      end
    end
  end

  // ---------------------------------------------------- partial angles
  sd_t         m_sd_q;
  sd_t         m_d;
  logic [45:0] pu_q;
  logic [45:0] pt_q;
  logic [30:0] ang;

  assign ang = vc_out[NS-1].z[CW-1] ? 31'd0 : vc_out[NS-1].z[30:0];

  always_comb begin
    m_d     = vc_sd_q[NS-1];
    m_d.ang = ang;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_sd_q <= m_d;
      pu_q   <= ang * vc_sd_q[NS-1].u;
      pt_q   <= ang * vc_sd_q[NS-1].t;
    end
  end

  // --------------------------------------------------------------- sines
  // lane 0: sin(a), lane 1: sin((1-t)a), lane 2: sin(t a)
  cordic_t sc_in  [3][NS];
  cordic_t sc_out [3][NS];
  sd_t     sc_sd_q [NS];

  assign sc_in[0][0] = '{x: INV_GAIN, y: '0, z: CW'(m_sd_q.ang)};
  assign sc_in[1][0] = '{x: INV_GAIN, y: '0, z: CW'(pu_q[45:14])};
  assign sc_in[2][0] = '{x: INV_GAIN, y: '0, z: CW'(pt_q[45:14])};

  for (genvar ln = 0; ln < 3; ln++) begin : g_sc_lane
    for (genvar k = 0; k < NS; k++) begin : g_sc_cell
      if (k > 0) begin : g_link
        assign sc_in[ln][k] = sc_out[ln][k-1];
      end
      qs_cordic_cell #(.STEP(k), .VECTOR(1'b0)) u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .d_i   (sc_in[ln][k]),
        .q_o   (sc_out[ln][k])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sc_sd_q[0] <= m_sd_q;
      for (int k = 1; k < NS; k++) begin
        sc_sd_q[k] <= sc_sd_q[k-1];
      end
    end
  end

  // ------------------------------------------------------------ division
  // lanes 0..3: linear components over the length, lanes 4..5: sine weights
  div_t                 dv_first [6];
  div_t                 dv_in  [6][DQ];
  div_t                 dv_out [6][DQ];
  sd_t                  dv_sd_q [DQ];
  sd_t                  dv_sd0;
  logic signed [CW-1:0] den;
  logic signed [CW-1:0] nrm   [2];
  logic        [DW-1:0] nclp  [2];
  logic        [44:0]   lnum  [4];

  always_comb begin
    den         = sc_out[0][NS-1].y;
    dv_sd0      = sc_sd_q[NS-1];
    // spherical weights only for a real angle with a positive sine
    dv_sd0.wsel = !sc_sd_q[NS-1].cone && !den[CW-1] && (den != '0);
    for (int j = 0; j < 2; j++) begin
      nrm[j] = sc_out[j+1][NS-1].y;
      if (nrm[j][CW-1]) begin
        nclp[j] = '0;
      end else if (nrm[j] > den) begin
        nclp[j] = den[DW-1:0];
      end else begin
        nclp[j] = nrm[j][DW-1:0];
      end
      dv_first[4+j] = '{rem: nclp[j] >> 1, dvs: den[DW-1:0],
                        num: {nclp[j][0], {(DQ-1){1'b0}}}, quo: '0};
    end
    for (int k = 0; k < 4; k++) begin
      // magnitude * 2^14 plus half the length, rounds half up
      lnum[k]     = {1'b0, sc_sd_q[NS-1].m[k], 14'b0}
                  + {14'b0, sc_sd_q[NS-1].len >> 1};
      dv_first[k] = '{rem: DW'(lnum[k][44:DQ]), dvs: sc_sd_q[NS-1].len,
                      num: lnum[k][DQ-1:0], quo: '0};
    end
  end

  for (genvar ln = 0; ln < 6; ln++) begin : g_dv_lane
    for (genvar k = 0; k < DQ; k++) begin : g_dv_cell
      if (k > 0) begin : g_link
        assign dv_in[ln][k] = dv_out[ln][k-1];
      end else begin : g_first
        assign dv_in[ln][k] = dv_first[ln];
      end
      qs_div_cell u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .d_i   (dv_in[ln][k]),
        .q_o   (dv_out[ln][k])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_sd_q[0] <= dv_sd0;
      for (int k = 1; k < DQ; k++) begin
        dv_sd_q[k] <= dv_sd_q[k-1];
      end
    end
  end

  // --------------------------------------------------------- weighting
  logic signed [45:0] f_ps_q [4];
  logic signed [46:0] f_pe_q [4];
  logic        [15:0] f_lr_q [4];
  logic               f_lin_q;
  logic               f_zero_q;
  logic        [29:0] w1;
  logic        [29:0] w2;
  logic               zero;
  logic        [15:0] lrv    [4];
  sd_t                fs;

  always_comb begin
    fs   = dv_sd_q[DQ-1];
    w1   = fs.wsel ? {1'b0, dv_out[4][DQ-1].quo} : {1'b0, fs.u, 14'b0};
    w2   = fs.wsel ? {1'b0, dv_out[5][DQ-1].quo} : {1'b0, fs.t, 14'b0};
    zero = fs.lin && (fs.len == '0);
    for (int k = 0; k < 4; k++) begin
      lrv[k] = {1'b0, dv_out[k][DQ-1].quo[14:0]};
      if (zero) begin
        lrv[k] = '0;
      end else if (fs.lneg[k]) begin
        lrv[k] = 16'd0 - lrv[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        f_ps_q[k] <= $signed(fs.s[k]) * $signed(w1);
        f_pe_q[k] <= $signed(fs.e[k]) * $signed(w2);
        f_lr_q[k] <= lrv[k];
      end
      f_lin_q  <= fs.lin;
      f_zero_q <= zero;
    end
  end

  // ------------------------------------------------- round, saturate, out
  logic signed [47:0] acc [4];
  logic signed [19:0] shr [4];
  logic        [15:0] res [4];
  logic        [15:0] out_q [4];
  logic               lin_q;
  logic               zero_q;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      acc[k] = 48'(f_ps_q[k]) + 48'(f_pe_q[k]) + 48'sd134217728;
      shr[k] = 20'(acc[k] >>> 28);
      if (f_lin_q) begin
        res[k] = f_lr_q[k];
      end else if (shr[k] > 20'sd32767) begin
        res[k] = 16'h7fff;
      end else if (shr[k] < -20'sd32768) begin
        res[k] = 16'h8000;
      end else begin
        res[k] = shr[k][15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q  <= res;
      lin_q  <= f_lin_q;
      zero_q <= f_zero_q;
    end
  end

  assign out_x_o       = out_q[0];
  assign out_y_o       = out_q[1];
  assign out_z_o       = out_q[2];
  assign out_w_o       = out_q[3];
  assign used_linear_o = lin_q;
  assign zero_length_o = zero_q;

  // ---------------------------------------------------------- checks
  // a held request leaves the skid as soon as the pipe moves
  `QS_ASSERT_NEXT(a_skid_drain, clk_i, rst_ni, (skid_v_q && en), !skid_v_q)
  // frozen pipe keeps its occupancy
  `QS_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, !en, (vld_q == $past(vld_q)))
  // a zero-length result only comes from the linear path
  `QS_ASSERT(a_zero_lin, clk_i, rst_ni, ((out_valid_o && zero_length_o) |-> used_linear_o))
  // and its components are all zero
  `QS_ASSERT(a_zero_out, clk_i, rst_ni, ((out_valid_o && zero_length_o) |-> ((out_x_o == 16'd0) && (out_y_o == 16'd0) && (out_z_o == 16'd0) && (out_w_o == 16'd0))))

endmodule

// File: verif/quaternion_slerp_tb.sv
module quaternion_slerp_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // one blended quaternion with its path flags
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic [15:0] w;
    logic        lin;
    logic        zl;
  } blend_res_t;

  // directed stimulus row, expected result only where it is obvious
  typedef struct {
    logic [14:0]       thr;
    logic [7:0][15:0]  q;
    logic [15:0]       bl;
    bit                has_exp;
    blend_res_t        exp_res;
  } blend_row_t;

  localparam int      STEPS      = 16;
  localparam longint  ONE_Q28    = 64'sd1 << 28;
  localparam longint  RECIP_GAIN = 64'sd163008219;
  localparam int      IDLE_LIMIT = 4000;
  localparam int      PHASE_LEN  = 290;

  // arctangent of 2^-i in q30 radians
  localparam longint ATAN_TBL [STEPS] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768
  };

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [14:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [15:0] start_x_i, start_y_i, start_z_i, start_w_i;
  logic [15:0] end_x_i, end_y_i, end_z_i, end_w_i;
  logic [15:0] blend_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] out_x_o, out_y_o, out_z_o, out_w_o;
  logic        used_linear_o;
  logic        zero_length_o;

  blend_res_t  blend_expected_q[$];
  logic [14:0] thr_model;
  int          mismatches;
  int          sent_cnt;
  int          lin_cnt;
  int          zl_cnt;
  int          sph_cnt;
  int          idle_cycles;
  bit          calm;
  blend_row_t  rows[$];

  quaternion_slerp DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .start_z_i     (start_z_i),
    .start_w_i     (start_w_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .end_z_i       (end_z_i),
    .end_w_i       (end_w_i),
    .blend_i       (blend_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .out_z_o       (out_z_o),
    .out_w_o       (out_w_o),
    .used_linear_o (used_linear_o),
    .zero_length_o (zero_length_o)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // floor square root, bit by bit
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // vectoring cordic, angle of (x, y) in q30
  function automatic longint angle_of(input longint x, input longint y);
    longint z;
    longint dx;
    longint dy;
    z = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += ATAN_TBL[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_TBL[i];
      end
    end
    return z;
  endfunction

  // rotating cordic, sine in q28
  function automatic longint sine_of(input longint ang);
    longint x;
    longint y;
    longint dx;
    longint dy;
    x = RECIP_GAIN;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (ang >= 0) begin
        x -= dx; y += dy; ang -= ATAN_TBL[i];
      end else begin
        x += dx; y -= dy; ang += ATAN_TBL[i];
      end
    end
    return y;
  endfunction

  function automatic longint clip16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // expected blend of one request under the given threshold
  function automatic blend_res_t blend_predict(input logic [7:0][15:0] q,
                                               input logic [15:0] bl,
                                               input logic [14:0] thr);
    longint s[4];
    longint e[4];
    longint l[4];
    longint res[4];
    longint dot, t, u, c, w1, w2, sn, a, den, n1, n2, acc, qt;
    longint unsigned sum, len, m;
    blend_res_t r;
    r.lin = 1'b0;
    r.zl  = 1'b0;
    for (int k = 0; k < 4; k++) begin
      s[k] = longint'($signed(q[k]));
      e[k] = longint'($signed(q[4+k]));
    end
    t = longint'($signed(bl));
    if (t < 0) t = 0;
    if (t > 16384) t = 16384;
    u = 16384 - t;
    dot = 0;
    for (int k = 0; k < 4; k++) dot += s[k] * e[k];
    // shortest arc: flip the end quaternion
    if (dot < 0) begin
      dot = -dot;
      for (int k = 0; k < 4; k++) e[k] = -e[k];
    end
    if (dot >= (longint'(thr) << 14)) begin
      r.lin = 1'b1;
      sum = 0;
      for (int k = 0; k < 4; k++) begin
        l[k] = s[k] * u + e[k] * t;
        m = (l[k] < 0) ? -l[k] : l[k];
        sum += m * m;
      end
      len = int_sqrt(sum);
      if (len == 0) begin
        r.zl = 1'b1;
        for (int k = 0; k < 4; k++) res[k] = 0;
      end else begin
        for (int k = 0; k < 4; k++) begin
          m = (l[k] < 0) ? -l[k] : l[k];
          qt = longint'(((m << 14) + (len >> 1)) / len);
          res[k] = clip16((l[k] < 0) ? -qt : qt);
        end
      end
    end else begin
      c  = (dot > ONE_Q28) ? ONE_Q28 : dot;
      w1 = u << 14;
      w2 = t << 14;
      // cosine at one or vanishing sine keep the linear weights
      if (c < ONE_Q28) begin
        sn = longint'(int_sqrt((64'd1 << 56) - longint'(c * c)));
        a  = angle_of(c, sn);
        if (a < 0) a = 0;
        den = sine_of(a);
        if (den > 0) begin
          n1 = sine_of((a * u) >>> 14);
          n2 = sine_of((a * t) >>> 14);
          if (n1 < 0) n1 = 0;
          if (n1 > den) n1 = den;
          if (n2 < 0) n2 = 0;
          if (n2 > den) n2 = den;
          w1 = (n1 << 28) / den;
          w2 = (n2 << 28) / den;
        end
      end
      for (int k = 0; k < 4; k++) begin
        acc = s[k] * w1 + e[k] * w2;
        res[k] = clip16((acc + (64'sd1 << 27)) >>> 28);
      end
    end
    r.x = res[0][15:0];
    r.y = res[1][15:0];
    r.z = res[2][15:0];
    r.w = res[3][15:0];
    return r;
  endfunction

  function automatic logic [7:0][15:0] quat_pair(
      input logic [15:0] sx, input logic [15:0] sy, input logic [15:0] sz,
      input logic [15:0] sw, input logic [15:0] ex, input logic [15:0] ey,
      input logic [15:0] ez, input logic [15:0] ew);
    return {ew, ez, ey, ex, sw, sz, sy, sx};
  endfunction

  function automatic blend_res_t res_of(input logic [15:0] x, input logic [15:0] y,
                                        input logic [15:0] z, input logic [15:0] w,
                                        input logic lin, input logic zl);
    blend_res_t r;
    r.x = x; r.y = y; r.z = z; r.w = w; r.lin = lin; r.zl = zl;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // wait until the pipe has handed back every pending result
  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    while (blend_expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [14:0] v);
    drain_pipe();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    thr_model = v;
  endtask

  // one request; valid stays high across back-to-back requests unless a random gap is inserted while not calm
  task automatic send_request(input logic [7:0][15:0] q, input logic [15:0] bl,
                              input bit has_exp, input blend_res_t exp_res);
    if (!calm && $urandom_range(99) < 23) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 23);
    end
    in_valid_i <= 1'b1;
    start_x_i <= q[0]; start_y_i <= q[1]; start_z_i <= q[2]; start_w_i <= q[3];
    end_x_i   <= q[4]; end_y_i   <= q[5]; end_z_i   <= q[6]; end_w_i   <= q[7];
    blend_i   <= bl;
    do @(posedge clk_i); while (!in_ready_o);
    blend_expected_q.push_back(has_exp ? exp_res : blend_predict(q, bl, thr_model));
    sent_cnt++;
  endtask

  // random request: mostly unnormalized pairs close together, some raw noise
  task automatic send_random();
    logic [7:0][15:0] q;
    logic [15:0] bl;
    int spread;
    int comp;
    blend_res_t none;
    none = '0;
    if ($urandom_range(9) < 3) begin
      for (int k = 0; k < 8; k++) q[k] = 16'($urandom);
    end else begin
      spread = ($urandom_range(3) == 0) ? 8000 : $urandom_range(0, 1500);
      for (int k = 0; k < 4; k++) begin
        comp = $urandom_range(0, 16383) - 8192;
        q[k] = 16'(comp);
        comp = comp + $urandom_range(0, 2 * spread) - spread;
        if (comp > 32767) comp = 32767;
        if (comp < -32768) comp = -32768;
        q[4+k] = 16'(comp);
      end
      // flipped end exercises the shortest arc path
      if ($urandom_range(1)) begin
        for (int k = 4; k < 8; k++) q[k] = 16'(-$signed(q[k]));
      end
    end
    if ($urandom_range(9) < 8) bl = 16'($urandom_range(0, 16384));
    else bl = 16'($urandom);
    send_request(q, bl, 1'b0, none);
  endtask

  // result checking and receiver stalls
  always @(posedge clk_i) begin
    blend_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (blend_expected_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = blend_expected_q.pop_front();
        if (out_x_o != want.x)
          report_mismatch("out_x", $signed(out_x_o), $signed(want.x));
        if (out_y_o != want.y)
          report_mismatch("out_y", $signed(out_y_o), $signed(want.y));
        if (out_z_o != want.z)
          report_mismatch("out_z", $signed(out_z_o), $signed(want.z));
        if (out_w_o != want.w)
          report_mismatch("out_w", $signed(out_w_o), $signed(want.w));
        if (used_linear_o != want.lin)
          report_mismatch("used_linear", used_linear_o, want.lin);
        if (zero_length_o != want.zl)
          report_mismatch("zero_length", zero_length_o, want.zl);
      end
      if (used_linear_o && zero_length_o) zl_cnt++;
      else if (used_linear_o) lin_cnt++;
      else sph_cnt++;
    end
    out_ready_i <= calm || ($urandom_range(99) >= 23);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [14:0] phase_thr [5];
    blend_res_t none;
    none        = '0;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    start_x_i = '0; start_y_i = '0; start_z_i = '0; start_w_i = '0;
    end_x_i   = '0; end_y_i   = '0; end_z_i   = '0; end_w_i   = '0;
    blend_i     = '0;
    out_ready_i = 1'b0;
    mismatches  = 0;
    sent_cnt    = 0;
    lin_cnt     = 0;
    zl_cnt      = 0;
    sph_cnt     = 0;
    idle_cycles = 0;
    calm        = 1'b0;
    thr_model   = 15'd15565;

    // reset threshold: zero inputs, identity, flipped end, clamped blend, orthogonal and extreme pairs
    rows.push_back('{15'd15565, quat_pair(0, 0, 0, 0, 0, 0, 0, 0), 16'd8192, 1,
                     res_of(0, 0, 0, 0, 0, 0)});
    rows.push_back('{15'd15565, quat_pair(0, 0, 0, 16384, 0, 0, 0, 16384), 16'd8192, 1,
                     res_of(0, 0, 0, 16384, 1, 0)});
    rows.push_back('{15'd15565, quat_pair(0, 0, 0, 16384, 0, 0, 0, -16'sd16384), 16'd4096,
                     1, res_of(0, 0, 0, 16384, 1, 0)});
    rows.push_back('{15'd15565, quat_pair(0, 0, 0, 16384, 0, 0, 0, 16384), 16'h8000, 1,
                     res_of(0, 0, 0, 16384, 1, 0)});
    rows.push_back('{15'd15565, quat_pair(0, 0, 0, 16384, 0, 0, 0, 16384), 16'h7fff, 1,
                     res_of(0, 0, 0, 16384, 1, 0)});
    rows.push_back('{15'd15565, quat_pair(0, 0, 0, 16384, 16384, 0, 0, 0), 16'd8192, 0,
                     none});
    rows.push_back('{15'd15565, quat_pair(0, 0, 0, 16384, 16384, 0, 0, 0), 16'd0, 0, none});
    rows.push_back('{15'd15565, quat_pair(0, 0, 0, 16384, 16384, 0, 0, 0), 16'd16384, 0,
                     none});
    rows.push_back('{15'd15565, quat_pair(16384, 0, 0, 0, 0, 0, 11585, 11585), 16'd5000, 0,
                     none});
    rows.push_back('{15'd15565, quat_pair(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000,
                     16'h8000, 16'h8000, 16'h8000), 16'd8192, 0, none});
    rows.push_back('{15'd15565, quat_pair(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                     16'h8000, 16'h8000, 16'h8000), 16'd16384, 0, none});
    rows.push_back('{15'd15565, quat_pair(16'h7fff, 0, 16'h8000, 0, 0, 16'h7fff, 0,
                     16'h8000), 16'd12000, 0, none});
    // threshold zero: everything takes the linear path, zero-length blends
    rows.push_back('{15'd0, quat_pair(0, 0, 0, 0, 0, 0, 0, 0), 16'd8192, 1,
                     res_of(0, 0, 0, 0, 1, 1)});
    rows.push_back('{15'd0, quat_pair(0, 0, 0, 0, 16384, 0, 0, 0), 16'd0, 1,
                     res_of(0, 0, 0, 0, 1, 1)});
    rows.push_back('{15'd0, quat_pair(0, 0, 0, 16384, 16384, 0, 0, 0), 16'd8192, 0, none});
    rows.push_back('{15'd0, quat_pair(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                     16'h7fff, 16'h7fff, 16'h7fff), 16'd3000, 0, none});
    // threshold one: tiny angles, sine close to vanishing
    rows.push_back('{15'd16384, quat_pair(0, 0, 0, 16384, 0, 0, 0, 16383), 16'd8192, 0,
                     none});
    rows.push_back('{15'd16384, quat_pair(0, 0, 0, 16384, 0, 0, 1, 16383), 16'd1, 0, none});
    rows.push_back('{15'd16384, quat_pair(0, 0, 1, 16383, 0, 0, 0, 16384), 16'd16383, 0,
                     none});
    // threshold above one: cosine at one stays spherical with linear weights
    rows.push_back('{15'h7fff, quat_pair(8192, 8192, 8192, 8192, 8192, 8192, 8192, 8192),
                     16'd8192, 1, res_of(8192, 8192, 8192, 8192, 0, 0)});
    rows.push_back('{15'h7fff, quat_pair(16384, 16384, 0, 0, 16384, 16384, 0, 0),
                     16'd2000, 0, none});

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (rows[i]) begin
      if (rows[i].thr != thr_model) write_threshold(rows[i].thr);
      send_request(rows[i].q, rows[i].bl, rows[i].has_exp, rows[i].exp_res);
    end

    // random phases over several thresholds
    phase_thr[0] = 15'd15565;
    phase_thr[1] = 15'd16384;
    phase_thr[2] = 15'($urandom_range(0, 16384));
    phase_thr[3] = 15'd0;
    phase_thr[4] = 15'd8192;
    for (int p = 0; p < 5; p++) begin
      write_threshold(phase_thr[p]);
      for (int n = 0; n < PHASE_LEN; n++) begin
        calm = (p == 1 && n < 200);
        // hold off until the pipe is empty once mid-phase
        if (p == 2 && n == 100) drain_pipe();
        send_random();
      end
      calm = 1'b0;
    end
    in_valid_i <= 1'b0;

    while (blend_expected_q.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);

    $display("sent %0d requests over %0d threshold settings", sent_cnt, 9);
    $display("results: %0d spherical, %0d linear, %0d zero length",
             sph_cnt, lin_cnt, zl_cnt);
    if (mismatches == 0 && blend_expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, blend_expected_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/qs_pkg.sv
src/qs_sqrt_cell.sv
src/qs_div_cell.sv
src/qs_cordic_cell.sv
src/quaternion_slerp.sv
verif/quaternion_slerp_tb.sv
